>>> hw/rtl/sle_pkg.sv
`timescale 1ns / 1ps
// Package for the serial line editor: request codes, character codes and payload types.
// Depends on nothing; serial_line_editor and its testbench import it.
package sle_pkg;

    localparam int BUF_LEN_DEFAULT = 64;

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       line_done;
        logic [5:0] line_length;
        logic [7:0] read_data;
    } out_item_t;

endpackage

>>> hw/rtl/sle_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload per transaction.
// Depends on nothing; the payload type is supplied by the instantiating module.
interface sle_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sle_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/serial_line_editor.sv
`timescale 1ns / 1ps
// Serial line editor: builds a text line from received bytes, with echo and erase editing.
// A result is offered in the cycle after its transaction; a read takes its data from the line
// RAM's registered port. One transaction per cycle while the output is taken, except that
// an erase holds the output register for three transfers (backspace, space, backspace).
// Reset clears the count, the line-complete flag and the output valid flag and sets edit mode;
// the line RAM is not cleared. Depends on sle_pkg, sle_stream_if and sle_ram.
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int BUF_LEN = BUF_LEN_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    sle_stream_if.sink   in_ch,
    sle_stream_if.source out_ch
);

    localparam int AW = $clog2(BUF_LEN);

    typedef struct packed {
        logic       erase;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rd_hit;
        logic       line_done;
        logic [5:0] line_length;
    } res_t;

    logic          edit_reg;
    logic [AW-1:0] count_reg, count_next;
    logic          complete_reg, complete_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    beat_reg, beat_next;
    res_t          res_reg, res_next;

    logic          accept;
    logic          out_last;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [AW+5:0] idx_wide;
    logic [AW+5:0] count_wide;
    in_item_t      item;

    assign item     = in_ch.payload;
    assign idx_wide = (AW + 6)'(item.read_index);
    assign rd_addr  = idx_wide[AW-1:0];
    assign out_last = !res_reg.erase || (beat_reg == 2'd2);
    assign in_ch.ready = !out_valid_reg || (out_ch.ready && out_last);
    assign accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        count_next    = count_reg;
        complete_next = complete_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg;
        wr_data       = 8'd0;
        rd_en         = 1'b0;
        res_next      = '0;
        case (item.req_type)
            REQ_BYTE:
            begin
                if (!complete_reg)
                begin
                    if (item.rx_byte == CH_CR || item.rx_byte == CH_LF)
                    begin
                        wr_en         = accept;
                        complete_next = 1'b1;
                    end
                    else if (edit_reg && (item.rx_byte == CH_BS || item.rx_byte == CH_DEL))
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.tx_valid = 1'b1;
                            res_next.tx_byte  = CH_BEL;
                        end
                        else
                        begin
                            count_next     = count_reg - AW'(1);
                            wr_en          = accept;
                            wr_addr        = count_reg - AW'(1);
                            res_next.erase = 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en   = accept;
                        wr_data = item.rx_byte;
                        if (count_reg == AW'(BUF_LEN - 1))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + AW'(1);
                        end
                        if (edit_reg)
                        begin
                            res_next.tx_valid = 1'b1;
                            res_next.tx_byte  = item.rx_byte;
                        end
                    end
                end
            end
            REQ_READ:
            begin
                rd_en           = accept;
                res_next.rd_hit = (idx_wide < (AW + 6)'(BUF_LEN));
            end
            REQ_RELEASE:
            begin
                count_next    = '0;
                complete_next = 1'b0;
            end
            default:
            begin
            end
        endcase
        count_wide           = (AW + 6)'(count_next);
        res_next.line_done   = complete_next;
        res_next.line_length = count_wide[5:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        beat_next      = beat_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            beat_next      = 2'd0;
        end
        else if (out_valid_reg && out_ch.ready)
        begin
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_reg      <= 1'b1;
            count_reg     <= '0;
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            beat_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                edit_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                count_reg    <= count_next;
                complete_reg <= complete_next;
            end
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    sle_ram #(
        .WIDTH (8),
        .DEPTH (BUF_LEN)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_ch.payload.last        = out_last;
        out_ch.payload.line_done   = res_reg.line_done;
        out_ch.payload.line_length = res_reg.line_length;
        out_ch.payload.read_data   = res_reg.rd_hit ? rd_data : 8'd0;
        if (res_reg.erase)
        begin
            out_ch.payload.tx_valid = 1'b1;
            out_ch.payload.tx_byte  = (beat_reg == 2'd1) ? CH_SP : CH_BS;
        end
        else
        begin
            out_ch.payload.tx_valid = res_reg.tx_valid;
            out_ch.payload.tx_byte  = res_reg.tx_byte;
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

>>> dv/serial_line_editor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_line_editor: directed and random line-editing traffic,
// checked transaction by transaction against a line-buffer predictor held in the testbench.
// Depends on sle_pkg, sle_stream_if and the serial_line_editor RTL.
module serial_line_editor_tb;
    import sle_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int LINE_SLOTS = BUF_LEN_DEFAULT;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic src_valid = 1'b0;
    in_item_t src_item = '0;
    logic sink_ready = 1'b0;
    logic rx_hold = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    int items_taken = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int gap_left = 0;
    int stall_left = 0;

    logic [7:0] line_mem [LINE_SLOTS];
    logic [5:0] line_cnt = '0;
    logic line_full = 1'b0;
    logic edit_on = 1'b1;

    in_item_t pending_reqs [$];
    out_item_t expected_replies [$];

    sle_stream_if #(.payload_t(in_item_t)) in_ch ();
    sle_stream_if #(.payload_t(out_item_t)) out_ch ();

    assign in_ch.valid = src_valid;
    assign in_ch.payload = src_item;
    assign out_ch.ready = sink_ready;

    serial_line_editor dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    function automatic out_item_t line_reply(logic txv, logic [7:0] txb, logic lst,
                                             logic [7:0] rdata);
        out_item_t r;
        r.tx_valid = txv;
        r.tx_byte = txb;
        r.last = lst;
        r.line_done = line_full;
        r.line_length = line_cnt;
        r.read_data = rdata;
        return r;
    endfunction

    task automatic predict_request(in_item_t it);
        case (it.req_type)
            REQ_BYTE:
            begin
                if (line_full)
                    expected_replies.push_back(line_reply(1'b0, 8'h00, 1'b1, 8'h00));
                else if (it.rx_byte == CH_CR || it.rx_byte == CH_LF)
                begin
                    line_mem[line_cnt] = 8'h00;
                    line_full = 1'b1;
                    expected_replies.push_back(line_reply(1'b0, 8'h00, 1'b1, 8'h00));
                end
                else if (edit_on && (it.rx_byte == CH_BS || it.rx_byte == CH_DEL))
                begin
                    if (line_cnt == 6'd0)
                        expected_replies.push_back(line_reply(1'b1, CH_BEL, 1'b1, 8'h00));
                    else
                    begin
                        line_cnt = line_cnt - 6'd1;
                        line_mem[line_cnt] = 8'h00;
                        expected_replies.push_back(line_reply(1'b1, CH_BS, 1'b0, 8'h00));
                        expected_replies.push_back(line_reply(1'b1, CH_SP, 1'b0, 8'h00));
                        expected_replies.push_back(line_reply(1'b1, CH_BS, 1'b1, 8'h00));
                    end
                end
                else
                begin
                    // The count is as wide as the buffer, so a full line wraps to zero.
                    line_mem[line_cnt] = it.rx_byte;
                    line_cnt = line_cnt + 6'd1;
                    expected_replies.push_back(line_reply(edit_on, edit_on ? it.rx_byte : 8'h00,
                                                          1'b1, 8'h00));
                end
            end
            REQ_READ:
                expected_replies.push_back(line_reply(1'b0, 8'h00, 1'b1,
                                                      line_mem[it.read_index]));
            REQ_RELEASE:
            begin
                line_full = 1'b0;
                line_cnt = 6'd0;
                expected_replies.push_back(line_reply(1'b0, 8'h00, 1'b1, 8'h00));
            end
            default:
                expected_replies.push_back(line_reply(1'b0, 8'h00, 1'b1, 8'h00));
        endcase
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s at reply %0d: got %0h, expected %0h",
                     what, replies_seen, got, want);
    endtask

    task automatic check_reply(out_item_t got);
        out_item_t want;
        replies_seen++;
        if (expected_replies.size() == 0)
        begin
            report_mismatch("unexpected transaction", 8'h00, 8'h00);
            return;
        end
        want = expected_replies.pop_front();
        if (got.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
        if (got.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
        if (got.last !== want.last)
            report_mismatch("last", 8'(got.last), 8'(want.last));
        if (got.line_done !== want.line_done)
            report_mismatch("line_done", 8'(got.line_done), 8'(want.line_done));
        if (got.line_length !== want.line_length)
            report_mismatch("line_length", 8'(got.line_length), 8'(want.line_length));
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (src_valid && in_ch.ready)
            begin
                predict_request(src_item);
                items_taken++;
            end
            if (!src_valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    src_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    src_item <= pending_reqs.pop_front();
                    src_valid <= 1'b1;
                    gap_left <= tx_quiet ? 0 : $urandom_range(0, 7);
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : sink_side
        int s;
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            s = -1;
            if (out_ch.valid && sink_ready)
            begin
                check_reply(out_ch.payload);
                s = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            if (rx_hold)
                sink_ready <= 1'b0;
            else if (s >= 0)
            begin
                stall_left <= s;
                sink_ready <= (s == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                sink_ready <= (stall_left == 1);
            end
            else
                sink_ready <= 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                holds_done++;
                rx_hold <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] any_index();
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = any_byte();
        while (b == CH_CR || b == CH_LF)
            b = any_byte();
        return b;
    endfunction

    task automatic push_req(logic [1:0] kind, logic [7:0] b, logic [5:0] idx);
        in_item_t it;
        it.req_type = kind;
        it.rx_byte = b;
        it.read_index = idx;
        pending_reqs.push_back(it);
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || src_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_edit_mode(logic on);
        settle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        edit_on = on;
    endtask

    task automatic queue_random_traffic(int n);
        int start;
        int len;
        int k;
        int erase_odds;
        start = pending_reqs.size();
        while (pending_reqs.size() - start < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    len = $urandom_range(66, 80);
                    erase_odds = 30;
                end
                else
                begin
                    len = $urandom_range(0, 12);
                    erase_odds = 5;
                end
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, erase_odds) == 0)
                        push_req(REQ_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL, any_index());
                    else
                        push_req(REQ_BYTE, text_byte(), any_index());
                end
                if ($urandom_range(0, 7) != 0)
                    push_req(REQ_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, any_index());
                len = $urandom_range(0, 4);
                for (k = 0; k < len; k++)
                    push_req(REQ_READ, any_byte(), any_index());
                len = $urandom_range(0, 2);
                for (k = 0; k < len; k++)
                    push_req(REQ_BYTE, any_byte(), any_index());
                if ($urandom_range(0, 9) != 0)
                    push_req(REQ_RELEASE, any_byte(), any_index());
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    push_req(2'($urandom_range(0, 3)), any_byte(), any_index());
            end
        end
    endtask

    initial
    begin : stimulus
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_edit_mode(1'b1);

        // A full line writes every buffer slot and wraps the count back to zero.
        for (k = 0; k < LINE_SLOTS; k++)
            push_req(REQ_BYTE, 8'h30 + 8'(k), 6'(k));

        push_req(REQ_BYTE, CH_BS, 6'h00);
        push_req(REQ_BYTE, CH_DEL, 6'h3f);
        push_req(REQ_BYTE, 8'h00, 6'h00);
        push_req(REQ_BYTE, 8'hff, 6'h3f);
        push_req(REQ_BYTE, 8'h80, 6'h00);
        push_req(REQ_BYTE, 8'h7e, 6'h15);
        push_req(REQ_BYTE, CH_BS, 6'h2a);
        push_req(REQ_BYTE, CH_DEL, 6'h00);
        push_req(REQ_READ, 8'hff, 6'h00);
        push_req(REQ_READ, 8'h00, 6'h3f);
        push_req(REQ_BYTE, CH_CR, 6'h00);
        push_req(REQ_BYTE, 8'h41, 6'h00);
        push_req(REQ_BYTE, CH_BS, 6'h00);
        push_req(REQ_READ, 8'h00, 6'h01);
        push_req(REQ_UNUSED, 8'hff, 6'h3f);
        push_req(REQ_RELEASE, 8'h00, 6'h00);
        push_req(REQ_BYTE, CH_LF, 6'h00);
        push_req(REQ_RELEASE, 8'hff, 6'h3f);
        push_req(REQ_RELEASE, 8'h00, 6'h00);

        set_edit_mode(1'b0);
        push_req(REQ_BYTE, CH_BS, 6'h00);
        push_req(REQ_BYTE, CH_DEL, 6'h00);
        push_req(REQ_BYTE, 8'h61, 6'h00);
        push_req(REQ_BYTE, CH_CR, 6'h00);
        push_req(REQ_READ, 8'h00, 6'h00);
        push_req(REQ_READ, 8'h00, 6'h01);
        push_req(REQ_RELEASE, 8'h00, 6'h00);

        set_edit_mode(1'b1);
        queue_random_traffic(55);
        settle();
        queue_random_traffic(55);

        // The sender keeps offering back to back while the receiver holds off.
        set_edit_mode(1'b0);
        tx_quiet = 1'b1;
        holds_asked++;
        queue_random_traffic(115);
        while (pending_reqs.size() > 40)
            @(posedge clk);
        tx_quiet = 1'b0;

        set_edit_mode(1'b1);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        queue_random_traffic(135);
        while (pending_reqs.size() > 80)
            @(posedge clk);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        settle();
        if (expected_replies.size() != 0)
            report_mismatch("replies never delivered", 8'(expected_replies.size()), 8'h00);
        $display("Covered %0d requests and %0d checked replies with edit mode on and off,",
                 items_taken, replies_seen);
        $display("including a %0d-cycle receiver hold-off and lines that overran the buffer.",
                 RX_HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run did not complete in time.");
        $display("tb: failure");
        $finish;
    end

endmodule
